// ===== hdl/acm_pkg.sv =====
package acm_pkg;

	// Converter and window sizing
	localparam int ADC_BITS = 10;
	localparam int ZERO_W   = 10;
	localparam int DEV_W    = (ADC_BITS > ZERO_W) ? ADC_BITS : ZERO_W;
	localparam int CNT_W    = 16;
	localparam int SUM_W    = DEV_W + CNT_W;
	localparam int P2P_W    = ADC_BITS + 1;

	// Register field widths
	localparam int WIN_W  = 16;
	localparam int MV_W   = 8;
	localparam int VCC_W  = 13;
	localparam int RV_W   = 8;
	localparam int MC_W   = 8;
	localparam int PF_W   = 9;

	// Result fields and their saturation limits
	localparam int CUR_W = 23;
	localparam int PWR_W = 31;
	localparam logic [CUR_W-1:0] CUR_MAX = 23'd5500000;
	localparam logic [PWR_W-1:0] PWR_MAX = 31'd1402500000;

	// Scaling constants: 0.3535 as Q0.16, milli scale, noise floor
	localparam int Q16_W = 15;
	localparam logic [Q16_W-1:0] Q16_0P3535 = 15'd23167;
	localparam logic [9:0]       MILLI      = 10'd1000;
	localparam logic [P2P_W-1:0] P2P_FLOOR  = P2P_W'(15);
	localparam int AC_SHIFT  = 26;
	localparam int DC_SHIFT  = 10;
	localparam int PWR_SHIFT = 8;

	// Shared multiplier and divider sizing
	localparam int MUL_A_W = SUM_W + VCC_W;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_W   = MUL_A_W;
	localparam int DEN_W   = CNT_W + 1 + MV_W;
	localparam int REM_W   = DEN_W + 1;
	localparam int DCNT_W  = $clog2(DIV_W);

	// Configuration port
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = 3;
	localparam int PDATA_W   = 32;

	localparam logic [REG_IDX_W-1:0] REG_AC_MODE      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_OFFSET  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MV_PER_AMP   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_VCC_MV       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RECV_VOLTAGE = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MAX_CURRENT  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_POWER_FACTOR = 3'd7;

endpackage

// ===== hdl/acm_if.sv =====
// Sample channel: one raw converter reading per item
interface acm_sample_if;
	logic                          valid;
	logic                          ready;
	logic [acm_pkg::ADC_BITS-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// Result channel: one measurement per window
interface acm_result_if;
	logic                       valid;
	logic                       ready;
	logic [acm_pkg::CUR_W-1:0]  current_milli;
	logic [acm_pkg::PWR_W-1:0]  power_milli;
	logic                       over_limit;

	modport source (output valid, output current_milli, output power_milli, output over_limit,
		input ready);
	modport sink (input valid, input current_milli, input power_milli, input over_limit,
		output ready);
endinterface

// ===== hdl/ac_dc_current_meter_top.sv =====
// Current meter for a Hall sensor read through an ADC.
// samples (sink): one raw reading per item. results (source): one item per window,
// carrying current in mA, power in mW and the over-limit flag.
// Registers are written over the APB port (psel/penable/pwrite, pready tied high),
// one register per word; the user must write them only while no window end is
// being worked out, as the block itself does not enforce this. Rate: samples that do
// not close the window are taken one per cycle while idle, so may arrive back to back.
// The sample that closes the window starts the scaling sequence, during which
// samples.ready is low; it runs on one shared multiplier and a one-bit-per-cycle
// restoring divider. When mv_per_amp is zero the current saturates without the divide.
// A finished result sits in the output register until taken; samples keep being
// accepted meanwhile. If the next window closes before the result is taken, the
// sequence holds in its last step until the receiver takes the earlier result.
// Reset: registers return to their defaults (AC mode, 1000-sample window), the
// window accumulators clear and no result is pending.
module ac_dc_current_meter_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [acm_pkg::PADDR_W-1:0]  paddr,
	input  logic [acm_pkg::PDATA_W-1:0]  pwdata,
	output logic [acm_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	acm_sample_if.sink                   samples,
	acm_result_if.source                 results
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_DLOAD,
		ST_DIV,
		ST_CSAT,
		ST_PWR1,
		ST_PWR2,
		ST_LIM,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic                        ac_mode_q;
	logic [acm_pkg::WIN_W-1:0]   win_q;
	logic [acm_pkg::ZERO_W-1:0]  zero_q;
	logic [acm_pkg::MV_W-1:0]    mv_q;
	logic [acm_pkg::VCC_W-1:0]   vcc_q;
	logic [acm_pkg::RV_W-1:0]    rv_q;
	logic [acm_pkg::MC_W-1:0]    mc_q;
	logic [acm_pkg::PF_W-1:0]    pf_q;

	// Window accumulators
	logic [acm_pkg::ADC_BITS-1:0] win_max_q;
	logic [acm_pkg::P2P_W-1:0]    win_min_q;
	logic [acm_pkg::SUM_W-1:0]    dev_sum_q;
	logic [acm_pkg::CNT_W-1:0]    smp_cnt_q;

	// Sequencer datapath
	logic [acm_pkg::MUL_P_W-1:0]  acc_q;
	logic [acm_pkg::DEN_W-1:0]    den_q;
	logic [acm_pkg::DIV_W-1:0]    rq_q;
	logic [acm_pkg::REM_W-1:0]    rem_q;
	logic [acm_pkg::DCNT_W-1:0]   dcnt_q;
	logic [acm_pkg::CUR_W-1:0]    cur_q;
	logic [acm_pkg::PWR_W-1:0]    pwr_q;
	logic                         res_valid_q;
	logic [acm_pkg::CUR_W-1:0]    res_cur_q;
	logic [acm_pkg::PWR_W-1:0]    res_pwr_q;
	logic                         res_over_q;

	logic                          cfg_wr;
	logic [acm_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          in_ready;
	logic                          in_acc;
	logic [acm_pkg::DEV_W-1:0]     smp_x;
	logic [acm_pkg::DEV_W-1:0]     zero_x;
	logic [acm_pkg::DEV_W-1:0]     dev;
	logic [acm_pkg::CNT_W-1:0]     cnt_nxt;
	logic [acm_pkg::CNT_W:0]       n_nxt;
	logic [acm_pkg::CNT_W:0]       n_cur;
	logic [acm_pkg::WIN_W-1:0]     win_eff;
	logic                          win_end;
	logic [acm_pkg::P2P_W-1:0]     p_raw;
	logic [acm_pkg::P2P_W-1:0]     p_eff;
	logic [acm_pkg::MUL_A_W-1:0]   mul_a;
	logic [acm_pkg::MUL_B_W-1:0]   mul_b;
	logic [acm_pkg::MUL_P_W-1:0]   mul_p;
	logic [acm_pkg::REM_W-1:0]     rem_sh;
	logic                          q_bit;
	logic [acm_pkg::MUL_P_W-acm_pkg::PWR_SHIFT-1:0] pwr_sh;
	logic                          res_load;
	logic                          win_clr;

	// Register access: write on the APB access phase, read back as stored
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[acm_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_mode_q <= 1'b1;
			win_q     <= acm_pkg::WIN_W'(1000);
			zero_q    <= acm_pkg::ZERO_W'(512);
			mv_q      <= acm_pkg::MV_W'(100);
			vcc_q     <= acm_pkg::VCC_W'(5000);
			rv_q      <= acm_pkg::RV_W'(230);
			mc_q      <= acm_pkg::MC_W'(10);
			pf_q      <= acm_pkg::PF_W'(256);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				acm_pkg::REG_AC_MODE:      ac_mode_q <= pwdata[0];
				acm_pkg::REG_WINDOW:       win_q     <= pwdata[acm_pkg::WIN_W-1:0];
				acm_pkg::REG_ZERO_OFFSET:  zero_q    <= pwdata[acm_pkg::ZERO_W-1:0];
				acm_pkg::REG_MV_PER_AMP:   mv_q      <= pwdata[acm_pkg::MV_W-1:0];
				acm_pkg::REG_VCC_MV:       vcc_q     <= pwdata[acm_pkg::VCC_W-1:0];
				acm_pkg::REG_RECV_VOLTAGE: rv_q      <= pwdata[acm_pkg::RV_W-1:0];
				acm_pkg::REG_MAX_CURRENT:  mc_q      <= pwdata[acm_pkg::MC_W-1:0];
				acm_pkg::REG_POWER_FACTOR: pf_q      <= pwdata[acm_pkg::PF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			acm_pkg::REG_AC_MODE:      prdata = acm_pkg::PDATA_W'(ac_mode_q);
			acm_pkg::REG_WINDOW:       prdata = acm_pkg::PDATA_W'(win_q);
			acm_pkg::REG_ZERO_OFFSET:  prdata = acm_pkg::PDATA_W'(zero_q);
			acm_pkg::REG_MV_PER_AMP:   prdata = acm_pkg::PDATA_W'(mv_q);
			acm_pkg::REG_VCC_MV:       prdata = acm_pkg::PDATA_W'(vcc_q);
			acm_pkg::REG_RECV_VOLTAGE: prdata = acm_pkg::PDATA_W'(rv_q);
			acm_pkg::REG_MAX_CURRENT:  prdata = acm_pkg::PDATA_W'(mc_q);
			acm_pkg::REG_POWER_FACTOR: prdata = acm_pkg::PDATA_W'(pf_q);
			default:                   prdata = '0;
		endcase
	end

	// Sample handshake and window bookkeeping
	assign in_ready      = (state_q == ST_IDLE);
	assign samples.ready = in_ready;
	assign in_acc        = samples.valid && in_ready;

	assign smp_x   = acm_pkg::DEV_W'(samples.sample);
	assign zero_x  = acm_pkg::DEV_W'(zero_q);
	assign dev     = (smp_x >= zero_x) ? (smp_x - zero_x) : (zero_x - smp_x);
	assign cnt_nxt = smp_cnt_q + 1'b1;
	assign n_nxt   = {~|cnt_nxt, cnt_nxt};
	assign n_cur   = {~|smp_cnt_q, smp_cnt_q};
	assign win_eff = (win_q == '0) ? acm_pkg::WIN_W'(1) : win_q;
	assign win_end = n_nxt >= {1'b0, win_eff};

	// Peak-to-peak swing, with the noise floor forced to zero
	assign p_raw = ({1'b0, win_max_q} >= win_min_q) ? ({1'b0, win_max_q} - win_min_q) : '0;
	assign p_eff = (p_raw <= acm_pkg::P2P_FLOOR) ? '0 : p_raw;

	// Accumulate every sample; clear once the window's result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_max_q <= '0;
			win_min_q <= {1'b1, {acm_pkg::ADC_BITS{1'b0}}};
			dev_sum_q <= '0;
			smp_cnt_q <= '0;
		end else if (win_clr) begin
			win_max_q <= '0;
			win_min_q <= {1'b1, {acm_pkg::ADC_BITS{1'b0}}};
			dev_sum_q <= '0;
			smp_cnt_q <= '0;
		end else if (in_acc) begin
			if (samples.sample > win_max_q)
				win_max_q <= samples.sample;
			if ({1'b0, samples.sample} < win_min_q)
				win_min_q <= {1'b0, samples.sample};
			dev_sum_q <= dev_sum_q + acm_pkg::SUM_W'(dev);
			smp_cnt_q <= cnt_nxt;
		end
	end

	// Shared multiplier: operands chosen by the sequencer step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL1: begin
				mul_a = ac_mode_q ? acm_pkg::MUL_A_W'(p_eff) : acm_pkg::MUL_A_W'(dev_sum_q);
				mul_b = acm_pkg::MUL_B_W'(vcc_q);
			end
			ST_MUL2: begin
				mul_a = acc_q[acm_pkg::MUL_A_W-1:0];
				mul_b = acm_pkg::MUL_B_W'(acm_pkg::MILLI);
			end
			ST_MUL3: begin
				if (ac_mode_q) begin
					mul_a = acc_q[acm_pkg::MUL_A_W-1:0];
					mul_b = acm_pkg::MUL_B_W'(acm_pkg::Q16_0P3535);
				end else begin
					mul_a = acm_pkg::MUL_A_W'(n_cur);
					mul_b = acm_pkg::MUL_B_W'(mv_q);
				end
			end
			ST_PWR1: begin
				mul_a = acm_pkg::MUL_A_W'(cur_q);
				mul_b = acm_pkg::MUL_B_W'(rv_q);
			end
			ST_PWR2: begin
				mul_a = acc_q[acm_pkg::MUL_A_W-1:0];
				mul_b = acm_pkg::MUL_B_W'(pf_q);
			end
			ST_LIM: begin
				mul_a = acm_pkg::MUL_A_W'(mc_q);
				mul_b = acm_pkg::MUL_B_W'(acm_pkg::MILLI);
			end
			default: ;
		endcase
	end

	assign mul_p = acm_pkg::MUL_P_W'(mul_a) * acm_pkg::MUL_P_W'(mul_b);

	// Restoring divider step: one quotient bit per cycle
	assign rem_sh = {rem_q[acm_pkg::REM_W-2:0], rq_q[acm_pkg::DIV_W-1]};
	assign q_bit  = rem_sh >= {1'b0, den_q};

	assign pwr_sh       = acc_q[acm_pkg::MUL_P_W-1:acm_pkg::PWR_SHIFT];
	assign res_load     = (state_q == ST_DONE) && (!res_valid_q || results.ready);
	assign win_clr      = res_load;

	// Sequencer: scale and divide (not at zero mv_per_amp), derive power and limit, then load the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			den_q       <= '0;
			rq_q        <= '0;
			rem_q       <= '0;
			dcnt_q      <= '0;
			cur_q       <= '0;
			pwr_q       <= '0;
			res_valid_q <= 1'b0;
			res_cur_q   <= '0;
			res_pwr_q   <= '0;
			res_over_q  <= 1'b0;
		end else begin
			if (res_valid_q && results.ready && !res_load)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && win_end) begin
						if (mv_q == '0) begin
							cur_q   <= acm_pkg::CUR_MAX;
							state_q <= ST_PWR1;
						end else begin
							state_q <= ST_MUL1;
						end
					end
				end
				ST_MUL1: begin
					acc_q   <= mul_p;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					acc_q   <= mul_p;
					state_q <= ST_MUL3;
				end
				ST_MUL3: begin
					if (ac_mode_q)
						acc_q <= mul_p;
					else
						den_q <= mul_p[acm_pkg::DEN_W-1:0];
					state_q <= ST_DLOAD;
				end
				ST_DLOAD: begin
					if (ac_mode_q) begin
						rq_q  <= acm_pkg::DIV_W'(acc_q >> acm_pkg::AC_SHIFT);
						den_q <= acm_pkg::DEN_W'(mv_q);
					end else begin
						rq_q  <= acm_pkg::DIV_W'(acc_q >> acm_pkg::DC_SHIFT);
					end
					rem_q   <= '0;
					dcnt_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= q_bit ? (rem_sh - {1'b0, den_q}) : rem_sh;
					rq_q   <= {rq_q[acm_pkg::DIV_W-2:0], q_bit};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == acm_pkg::DCNT_W'(acm_pkg::DIV_W - 1))
						state_q <= ST_CSAT;
				end
				ST_CSAT: begin
					cur_q   <= (rq_q > acm_pkg::DIV_W'(acm_pkg::CUR_MAX)) ?
						acm_pkg::CUR_MAX : rq_q[acm_pkg::CUR_W-1:0];
					state_q <= ST_PWR1;
				end
				ST_PWR1: begin
					acc_q   <= mul_p;
					state_q <= ST_PWR2;
				end
				ST_PWR2: begin
					acc_q   <= mul_p;
					state_q <= ST_LIM;
				end
				ST_LIM: begin
					pwr_q   <= (pwr_sh > ($bits(pwr_sh))'(acm_pkg::PWR_MAX)) ?
						acm_pkg::PWR_MAX : pwr_sh[acm_pkg::PWR_W-1:0];
					acc_q   <= mul_p;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_load) begin
						res_valid_q <= 1'b1;
						res_cur_q   <= cur_q;
						res_pwr_q   <= pwr_q;
						res_over_q  <= acm_pkg::MUL_P_W'(cur_q) > acc_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid         = res_valid_q;
	assign results.current_milli = res_cur_q;
	assign results.power_milli   = res_pwr_q;
	assign results.over_limit    = res_over_q;

endmodule

// ===== hdl/acm_checker.sv =====
module acm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [acm_pkg::CUR_W-1:0]  res_cur,
	input logic [acm_pkg::PWR_W-1:0]  res_pwr,
	input logic                       res_over
);

	// Results never pass their saturation limits
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_cur <= acm_pkg::CUR_MAX) && (res_pwr <= acm_pkg::PWR_MAX))
		else $error("result beyond saturation limit");

	// No current means no power
	a_zero_pwr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_cur == '0) |-> (res_pwr == '0))
		else $error("power without current");

	// The limit flag needs a non-zero current
	a_over: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_over |-> (res_cur != '0))
		else $error("over-limit flag at zero current");

	// Hold a stalled item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_cur) && $stable(res_pwr)
			&& $stable(res_over))
		else $error("stalled item changed");

endmodule

bind ac_dc_current_meter_top acm_checker u_acm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_cur   (results.current_milli),
	.res_pwr   (results.power_milli),
	.res_over  (results.over_limit)
);

// ===== tb/testbench.sv =====
module testbench;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned SETTLE       = 64;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned RANDOM_ITEMS = 1250;
	localparam int unsigned SAMPLE_TOP   = (1 << acm_pkg::ADC_BITS) - 1;

	// Scaling of the meter
	localparam logic [63:0] RMS_Q16     = 64'd23167;
	localparam logic [63:0] MILLI_SCALE = 64'd1000;
	localparam logic [63:0] ADC_SPAN    = 64'd1024;
	localparam logic [63:0] Q16_ONE     = 64'd65536;
	localparam logic [63:0] NOISE_FLOOR = 64'd15;
	localparam logic [63:0] CUR_LIMIT   = 64'd5500000;
	localparam logic [63:0] PWR_LIMIT   = 64'd1402500000;
	localparam int          PF_SHIFT    = 8;

	typedef struct packed {
		logic [acm_pkg::CUR_W-1:0] current_milli;
		logic [acm_pkg::PWR_W-1:0] power_milli;
		logic                      over_limit;
	} reading_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [acm_pkg::PADDR_W-1:0] paddr;
	logic [acm_pkg::PDATA_W-1:0] pwdata;
	logic [acm_pkg::PDATA_W-1:0] prdata;
	logic                        pready;

	acm_sample_if sample_ch();
	acm_result_if result_ch();

	ac_dc_current_meter_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (sample_ch),
		.results (result_ch)
	);

	// Register copies, at reset values
	logic                       cfg_ac_mode = 1'b1;
	logic [acm_pkg::WIN_W-1:0]  cfg_window  = 16'd1000;
	logic [acm_pkg::ZERO_W-1:0] cfg_zero    = 10'd512;
	logic [acm_pkg::MV_W-1:0]   cfg_mv      = 8'd100;
	logic [acm_pkg::VCC_W-1:0]  cfg_vcc     = 13'd5000;
	logic [acm_pkg::RV_W-1:0]   cfg_recv    = 8'd230;
	logic [acm_pkg::MC_W-1:0]   cfg_max     = 8'd10;
	logic [acm_pkg::PF_W-1:0]   cfg_pf      = 9'd256;

	// Window accumulators
	logic [acm_pkg::ADC_BITS-1:0] win_max   = '0;
	logic [acm_pkg::ADC_BITS:0]   win_min   = {1'b1, {acm_pkg::ADC_BITS{1'b0}}};
	logic [63:0]                  dev_sum   = '0;
	logic [acm_pkg::CNT_W-1:0]    win_count = '0;

	logic [acm_pkg::ADC_BITS-1:0] pending_samples[$];
	reading_t                     expected_readings[$];

	int unsigned error_count   = 0;
	int unsigned cycle_count   = 0;
	int unsigned tx_gap_max    = 14;
	int unsigned rx_gap_max    = 14;
	int unsigned tx_gap;
	int unsigned rx_wait;
	int unsigned hold_requests = 0;
	int unsigned hold_served;
	int unsigned hold_left;

	always #10 clk = ~clk;

	// Fold one sample into the window and predict the reading at window end
	function automatic void take_sample(input logic [acm_pkg::ADC_BITS-1:0] s);
		logic [63:0] limit;
		logic [63:0] n;
		logic [63:0] swing;
		logic [63:0] current;
		logic [63:0] power;
		reading_t    r;
		limit = (cfg_window == 0) ? 64'd1 : 64'(cfg_window);
		if (s > win_max)
			win_max = s;
		if ({1'b0, s} < win_min)
			win_min = {1'b0, s};
		if (s >= cfg_zero)
			dev_sum += 64'(s - cfg_zero);
		else
			dev_sum += 64'(cfg_zero - s);
		win_count = win_count + 1'b1;
		n = (win_count == 0) ? 64'd65536 : 64'(win_count);
		if (n < limit)
			return;

		if (cfg_mv == 0) begin
			current = CUR_LIMIT;
		end else if (cfg_ac_mode) begin
			swing = ({1'b0, win_max} >= win_min) ? 64'(win_max) - 64'(win_min) : 64'd0;
			// drop swings inside the noise floor
			if (swing <= NOISE_FLOOR)
				swing = 64'd0;
			current = (swing * 64'(cfg_vcc) * RMS_Q16 * MILLI_SCALE) /
				(64'(cfg_mv) * ADC_SPAN * Q16_ONE);
		end else begin
			current = (dev_sum * 64'(cfg_vcc) * MILLI_SCALE) / (n * 64'(cfg_mv) * ADC_SPAN);
		end
		if (current > CUR_LIMIT)
			current = CUR_LIMIT;
		power = (current * 64'(cfg_recv) * 64'(cfg_pf)) >> PF_SHIFT;
		if (power > PWR_LIMIT)
			power = PWR_LIMIT;

		r.current_milli = current[acm_pkg::CUR_W-1:0];
		r.power_milli   = power[acm_pkg::PWR_W-1:0];
		r.over_limit    = (current > 64'(cfg_max) * MILLI_SCALE);
		expected_readings.push_back(r);

		win_max   = '0;
		win_min   = {1'b1, {acm_pkg::ADC_BITS{1'b0}}};
		dev_sum   = '0;
		win_count = '0;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// Write one register over the APB port: setup, then access
	task automatic write_reg(input logic [acm_pkg::REG_IDX_W-1:0] idx,
		input int unsigned value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= acm_pkg::PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			acm_pkg::REG_AC_MODE:      cfg_ac_mode = value[0];
			acm_pkg::REG_WINDOW:       cfg_window  = value[acm_pkg::WIN_W-1:0];
			acm_pkg::REG_ZERO_OFFSET:  cfg_zero    = value[acm_pkg::ZERO_W-1:0];
			acm_pkg::REG_MV_PER_AMP:   cfg_mv      = value[acm_pkg::MV_W-1:0];
			acm_pkg::REG_VCC_MV:       cfg_vcc     = value[acm_pkg::VCC_W-1:0];
			acm_pkg::REG_RECV_VOLTAGE: cfg_recv    = value[acm_pkg::RV_W-1:0];
			acm_pkg::REG_MAX_CURRENT:  cfg_max     = value[acm_pkg::MC_W-1:0];
			acm_pkg::REG_POWER_FACTOR: cfg_pf      = value[acm_pkg::PF_W-1:0];
			default: ;
		endcase
	endtask

	// Wait until every sample is taken and every reading is in, then let the block settle
	task automatic settle();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || sample_ch.valid || expected_readings.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Now and then the range ends or the over-range top, mostly anywhere in range
	function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi,
		input int unsigned top);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			2: return top;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	// Queue samples around a band, with full-scale, zero and random ones mixed in
	task automatic fill_samples(input int unsigned count);
		int unsigned centre;
		int unsigned spread;
		int unsigned v;
		centre = $urandom_range(0, SAMPLE_TOP);
		spread = $urandom_range(0, 40);
		for (int unsigned i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1: v = $urandom_range(0, SAMPLE_TOP);
				2: v = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
				default: v = centre + $urandom_range(0, spread);
			endcase
			if (v > SAMPLE_TOP)
				v = SAMPLE_TOP;
			pending_samples.push_back(v[acm_pkg::ADC_BITS-1:0]);
		end
	endtask

	// Offer queued samples, with a drawn gap after each item; predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid  <= 1'b0;
			sample_ch.sample <= '0;
			tx_gap           <= 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready)
				take_sample(sample_ch.sample);
			if (!sample_ch.valid || sample_ch.ready) begin
				if (tx_gap != 0) begin
					sample_ch.valid <= 1'b0;
					tx_gap          <= tx_gap - 1;
				end else if (pending_samples.size() != 0) begin
					sample_ch.valid  <= 1'b1;
					sample_ch.sample <= pending_samples.pop_front();
					tx_gap           <= $urandom_range(0, tx_gap_max);
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Take readings, check them against the oldest prediction, and pace ready
	always @(posedge clk or negedge arst_n) begin : result_sink
		reading_t    want;
		int unsigned draw;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_wait         <= 0;
			hold_left       <= 0;
			hold_served     <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_readings.size() == 0) begin
					report_mismatch("reading with none predicted, current_milli",
						result_ch.current_milli, 0);
				end else begin
					want = expected_readings.pop_front();
					if (result_ch.current_milli !== want.current_milli)
						report_mismatch("current_milli", result_ch.current_milli,
							want.current_milli);
					if (result_ch.power_milli !== want.power_milli)
						report_mismatch("power_milli", result_ch.power_milli, want.power_milli);
					if (result_ch.over_limit !== want.over_limit)
						report_mismatch("over_limit", result_ch.over_limit, want.over_limit);
				end
			end

			// a long hold lets the block fill up and stall its input
			if (hold_served != hold_requests) begin
				hold_served     <= hold_requests;
				hold_left       <= HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left       <= hold_left - 1;
				result_ch.ready <= 1'b0;
			end else if (result_ch.valid && result_ch.ready) begin
				draw = $urandom_range(0, rx_gap_max);
				rx_wait         <= draw;
				result_ch.ready <= (draw == 0);
			end else if (rx_wait != 0) begin
				rx_wait         <= rx_wait - 1;
				result_ch.ready <= (rx_wait == 1);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned phase;
		int unsigned count;
		int unsigned w;
		int unsigned random_items;
		phase        = 0;
		random_items = 0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults apart from the window: AC mode, full-scale swing
		write_reg(acm_pkg::REG_WINDOW, 4);
		pending_samples.push_back(10'd0);
		pending_samples.push_back(10'd1023);
		pending_samples.push_back(10'd512);
		pending_samples.push_back(10'd512);
		// a swing at the noise floor reads as zero, one above it does not
		pending_samples.push_back(10'd100);
		pending_samples.push_back(10'd115);
		pending_samples.push_back(10'd110);
		pending_samples.push_back(10'd105);
		pending_samples.push_back(10'd100);
		pending_samples.push_back(10'd116);
		pending_samples.push_back(10'd108);
		pending_samples.push_back(10'd108);
		settle();

		// DC average about the default zero offset
		write_reg(acm_pkg::REG_AC_MODE, 0);
		write_reg(acm_pkg::REG_WINDOW, 3);
		pending_samples.push_back(10'd0);
		pending_samples.push_back(10'd1023);
		pending_samples.push_back(10'd512);
		settle();

		// a zero window length behaves as one sample
		write_reg(acm_pkg::REG_WINDOW, 0);
		pending_samples.push_back(10'd1023);
		pending_samples.push_back(10'd0);
		settle();

		// zero sensitivity saturates the current
		write_reg(acm_pkg::REG_MV_PER_AMP, 0);
		pending_samples.push_back(10'd700);
		settle();

		// over-range supply and power factor, both results saturated
		write_reg(acm_pkg::REG_MV_PER_AMP, 1);
		write_reg(acm_pkg::REG_VCC_MV, 8191);
		write_reg(acm_pkg::REG_POWER_FACTOR, 511);
		write_reg(acm_pkg::REG_RECV_VOLTAGE, 255);
		write_reg(acm_pkg::REG_MAX_CURRENT, 0);
		write_reg(acm_pkg::REG_ZERO_OFFSET, 0);
		write_reg(acm_pkg::REG_WINDOW, 2);
		pending_samples.push_back(10'd1023);
		pending_samples.push_back(10'd1023);
		settle();

		// shrink the window below the samples already taken
		write_reg(acm_pkg::REG_AC_MODE, 1);
		write_reg(acm_pkg::REG_MV_PER_AMP, 100);
		write_reg(acm_pkg::REG_VCC_MV, 5000);
		write_reg(acm_pkg::REG_POWER_FACTOR, 256);
		write_reg(acm_pkg::REG_RECV_VOLTAGE, 230);
		write_reg(acm_pkg::REG_MAX_CURRENT, 10);
		write_reg(acm_pkg::REG_WINDOW, 65535);
		pending_samples.push_back(10'd200);
		pending_samples.push_back(10'd800);
		pending_samples.push_back(10'd500);
		settle();
		write_reg(acm_pkg::REG_WINDOW, 2);
		pending_samples.push_back(10'd600);
		settle();

		// switch mode half way through a window
		write_reg(acm_pkg::REG_AC_MODE, 0);
		write_reg(acm_pkg::REG_WINDOW, 4);
		pending_samples.push_back(10'd300);
		pending_samples.push_back(10'd900);
		settle();
		write_reg(acm_pkg::REG_AC_MODE, 1);
		pending_samples.push_back(10'd310);
		pending_samples.push_back(10'd320);

		// Random phases; windows left part-way carry into the next setting
		while (random_items < RANDOM_ITEMS) begin
			settle();
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
			if (phase == 2) begin
				// one reading per sample, back to back, against a long receiver hold
				write_reg(acm_pkg::REG_WINDOW, 1);
				write_reg(acm_pkg::REG_MV_PER_AMP, 100);
				tx_gap_max = 0;
				rx_gap_max = 0;
				count = 40;
				hold_requests++;
				fill_samples(count);
			end else begin
				if (phase == 0 || $urandom_range(0, 2) == 0)
					write_reg(acm_pkg::REG_AC_MODE, $urandom_range(0, 1));
				if (phase == 0 || $urandom_range(0, 2) == 0) begin
					case ($urandom_range(0, 19))
						0: w = 0;
						1: w = 1;
						2: w = 65535;
						3, 4: w = $urandom_range(60, 200);
						default: w = $urandom_range(1, 24);
					endcase
					write_reg(acm_pkg::REG_WINDOW, w);
				end
				if (phase == 0 || $urandom_range(0, 2) == 0)
					write_reg(acm_pkg::REG_ZERO_OFFSET, pick_value(0, 1023, 1023));
				if (phase == 0 || $urandom_range(0, 2) == 0)
					write_reg(acm_pkg::REG_MV_PER_AMP, pick_value(0, 255, 1));
				if (phase == 0 || $urandom_range(0, 2) == 0)
					write_reg(acm_pkg::REG_VCC_MV, pick_value(0, 5500, 8191));
				if (phase == 0 || $urandom_range(0, 2) == 0)
					write_reg(acm_pkg::REG_RECV_VOLTAGE, pick_value(0, 255, 255));
				if (phase == 0 || $urandom_range(0, 2) == 0)
					write_reg(acm_pkg::REG_MAX_CURRENT, pick_value(0, 255, 255));
				if (phase == 0 || $urandom_range(0, 2) == 0)
					write_reg(acm_pkg::REG_POWER_FACTOR, pick_value(0, 256, 511));
				w = (cfg_window == 0) ? 1 : cfg_window;
				count = (w > 60) ? $urandom_range(40, 150) : $urandom_range(1, 3 * w + 4);
				fill_samples(count);
			end
			random_items += count;
			phase++;
		end
		settle();

		if (expected_readings.size() != 0)
			report_mismatch("readings never delivered", 0, expected_readings.size());
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/acm_pkg.sv
hdl/acm_if.sv
hdl/ac_dc_current_meter_top.sv
hdl/acm_checker.sv
tb/testbench.sv
